>>> rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg: shared types and constants of the integer matrix multiplier
// Field widths, operation codes, register indexes and pipeline structs.
// ----------------------------------------------------------------------------
package imm_pkg;

  // default largest matrix dimension
  localparam int MAX_DIM_DEF = 8;

  // payload widths
  localparam int OP_W      = 2;
  localparam int IDX_W     = 3;
  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int SUM_W     = 35;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // register reset value
  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(4);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = CFG_IDX_W'(3);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_A = 2'd0,
    OP_WR_B = 2'd1,
    OP_MUL  = 2'd2
  } op_t;

  // one multiply-accumulate step issued by the sequencer
  typedef struct packed {
    logic             valid;
    logic             first;   // first k of a sum
    logic             last_k;  // final k of a sum
    logic             last;    // sum is the final element of the product
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  // finished sum leaving the MAC unit
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] sum;
  } res_t;

endpackage

>>> rtl/imm_if.sv
// ----------------------------------------------------------------------------
// imm_in_if / imm_out_if: valid/ready channels of the matrix multiplier
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface imm_in_if;
  import imm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [IDX_W-1:0]        elem_row;
  logic [IDX_W-1:0]        elem_col;
  logic signed [VAL_W-1:0] elem_value;

  modport source (output valid, operation, elem_row, elem_col, elem_value,
                  input ready);
  modport sink   (input valid, operation, elem_row, elem_col, elem_value,
                  output ready);
endinterface

interface imm_out_if;
  import imm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [SUM_W-1:0] product_sum;
  logic                    dim_error;
  logic                    last;

  modport source (output valid, out_row, out_col, product_sum, dim_error, last,
                  input ready);
  modport sink   (input valid, out_row, out_col, product_sum, dim_error, last,
                  output ready);
endinterface

>>> rtl/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac: shared multiply-accumulate unit
// Registers the 16x16 product, then accumulates one term per step and
// presents the finished sum on the final step of each element.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  imm_pkg::tag_t                    tag_in,
  input  logic signed [imm_pkg::VAL_W-1:0] a_data,
  input  logic signed [imm_pkg::VAL_W-1:0] b_data,
  output imm_pkg::res_t                    res,
  output logic                             busy
);
  import imm_pkg::*;

  tag_t                     s1_r;    // aligned with RAM read data
  tag_t                     s2_r;    // aligned with product register
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic signed [SUM_W-1:0]  acc_base;
  logic signed [SUM_W-1:0]  sum_nxt;

  // accumulate: a new sum starts from the first product
  assign acc_base = s2_r.first ? '0 : acc_r;
  assign sum_nxt  = acc_base + SUM_W'(prod_r);

  // step tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (adv) begin
      s1_r <= tag_in;
      s2_r <= s1_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_r.valid) begin
        prod_r <= a_data * b_data;
      end
      if (s2_r.valid) begin
        acc_r <= sum_nxt;
      end
    end
  end

  assign res.valid = s2_r.valid && s2_r.last_k;
  assign res.last  = s2_r.last;
  assign res.row   = s2_r.row;
  assign res.col   = s2_r.col;
  assign res.sum   = sum_nxt;

  assign busy = s1_r.valid || s2_r.valid;

endmodule

>>> rtl/imm_seq.sv
// ----------------------------------------------------------------------------
// imm_seq: command decode and walk sequencer
// Holds the dimension registers, steers element writes into the stores and
// walks row, column and inner index for a multiply command.
// ----------------------------------------------------------------------------
module imm_seq #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // configuration
  input  logic                                    cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]               cfg_data,
  // commands
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [imm_pkg::OP_W-1:0]                in_op,
  input  logic [imm_pkg::IDX_W-1:0]               in_row,
  input  logic [imm_pkg::IDX_W-1:0]               in_col,
  // pipeline control
  input  logic                                    adv,
  input  logic                                    busy,
  output imm_pkg::tag_t                           tag,
  output logic                                    err_load,
  // store ports
  output logic                                    a_we,
  output logic                                    b_we,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      waddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      a_raddr,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      b_raddr
);
  import imm_pkg::*;

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int IW = $clog2(MAX_DIM);
  localparam int CW = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_ERR} state_t;

  state_t           state_r;
  logic [CFG_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [CW-1:0]    nr_r, nk_r, nc_r;
  logic [IW-1:0]    i_r, j_r, k_r;
  logic             accept;
  logic             wr_ok;
  logic             k_end, j_end, i_end;

  // saturate a dimension register to 1..MAX_DIM
  function automatic logic [CW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = CW'(MAX_DIM);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // element writes, out-of-range indexes dropped
  assign wr_ok = accept && (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign a_we  = wr_ok && (in_op == OP_WR_A);
  assign b_we  = wr_ok && (in_op == OP_WR_B);
  assign waddr = AW'(int'(in_row) * MAX_DIM + int'(in_col));

  // walk addresses
  assign a_raddr = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_raddr = AW'(int'(k_r) * MAX_DIM + int'(j_r));

  assign k_end = (CW'(k_r) == nk_r - CW'(1));
  assign j_end = (CW'(j_r) == nc_r - CW'(1));
  assign i_end = (CW'(i_r) == nr_r - CW'(1));

  // step issued to the MAC
  assign tag.valid  = (state_r == ST_WALK);
  assign tag.first  = (k_r == '0);
  assign tag.last_k = k_end;
  assign tag.last   = i_end && j_end;
  assign tag.row    = IDX_W'(i_r);
  assign tag.col    = IDX_W'(j_r);

  assign err_load = (state_r == ST_ERR) && adv;

  // state, counters and dimension registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      a_rows_r <= DIM_RESET;
      a_cols_r <= DIM_RESET;
      b_rows_r <= DIM_RESET;
      b_cols_r <= DIM_RESET;
      nr_r     <= CW'(1);
      nk_r     <= CW'(1);
      nc_r     <= CW'(1);
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_A_ROWS: a_rows_r <= cfg_data;
          REG_A_COLS: a_cols_r <= cfg_data;
          REG_B_ROWS: b_rows_r <= cfg_data;
          REG_B_COLS: b_cols_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (accept && (in_op == OP_MUL)) begin
            if (a_cols_r != b_rows_r) begin
              state_r <= ST_ERR;
            end else begin
              state_r <= ST_WALK;
              nr_r    <= clamp_dim(a_rows_r);
              nk_r    <= clamp_dim(a_cols_r);
              nc_r    <= clamp_dim(b_cols_r);
              i_r     <= '0;
              j_r     <= '0;
              k_r     <= '0;
            end
          end
        end
        ST_WALK: begin
          if (adv) begin
            if (!k_end) begin
              k_r <= k_r + IW'(1);
            end else begin
              k_r <= '0;
              if (!j_end) begin
                j_r <= j_r + IW'(1);
              end else begin
                j_r <= '0;
                if (i_end) begin
                  state_r <= ST_DRAIN;
                end else begin
                  i_r <= i_r + IW'(1);
                end
              end
            end
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state_r <= ST_IDLE;
          end
        end
        ST_ERR: begin
          if (adv) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply: small signed integer matrix multiplier
// Stores A and B element by element and streams C = A x B in row-major order
// through one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake        payload
//   in_chan   in   valid / ready    operation, elem_row, elem_col, elem_value
//   out_chan  out  valid / ready    out_row, out_col, product_sum, dim_error,
//                                   last
//   cfg_*     in   cfg_we only      cfg_index, cfg_data
//
// Element writes are accepted back to back.
// A multiply walks nr * nc * nk inner steps through the MAC (one inner step
// per cycle while the output register can take results), then drains the
// pipeline; in_chan is not ready meanwhile. A dimension mismatch returns a
// single flagged result. The stores have no reset and no clearing pass. While
// a result sits in the output register untaken, the read, multiply and
// accumulate steps all hold.
//
module integer_matrix_multiply #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]     cfg_data,
  imm_in_if.sink                        in_chan,
  imm_out_if.source                     out_chan
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  tag_t             tag;
  res_t             res;
  logic             adv;
  logic             busy;
  logic             err_load;
  logic             a_we, b_we;
  logic [AW-1:0]    waddr, a_raddr, b_raddr;
  logic [VAL_W-1:0] a_data, b_data;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic                    out_err_r, out_last_r;

  // pipeline moves whenever the output register can take a result
  assign adv = !out_valid_r || out_chan.ready;

  imm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_op     (in_chan.operation),
    .in_row    (in_chan.elem_row),
    .in_col    (in_chan.elem_col),
    .adv       (adv),
    .busy      (busy),
    .tag       (tag),
    .err_load  (err_load),
    .a_we      (a_we),
    .b_we      (b_we),
    .waddr     (waddr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr)
  );

  imm_ram #(.W(VAL_W), .D(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (in_chan.elem_value),
    .re    (adv),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  imm_ram #(.W(VAL_W), .D(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (in_chan.elem_value),
    .re    (adv),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  imm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .tag_in (tag),
    .a_data (a_data),
    .b_data (b_data),
    .res    (res),
    .busy   (busy)
  );

  // output register: error result or finished sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (err_load) begin
      out_valid_r <= 1'b1;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (err_load) begin
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_sum_r  <= '0;
      out_err_r  <= 1'b1;
      out_last_r <= 1'b1;
    end else if (adv && res.valid) begin
      out_row_r  <= res.row;
      out_col_r  <= res.col;
      out_sum_r  <= res.sum;
      out_err_r  <= 1'b0;
      out_last_r <= res.last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_row     = out_row_r;
  assign out_chan.out_col     = out_col_r;
  assign out_chan.product_sum = out_sum_r;
  assign out_chan.dim_error   = out_err_r;
  assign out_chan.last        = out_last_r;

`ifndef SYNTH
  // no command is taken while steps are still in the MAC
  a_idle_when_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && busy))
    else $error("command accepted while MAC busy");

  // an issued step shows up in the MAC pipeline
  a_issue_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (tag.valid && adv) |=> busy)
    else $error("issued step lost");

  // a finished sum is held while the output register is blocked
  a_res_held : assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !adv) |=> (res.valid && $stable(res.sum)))
    else $error("finished sum dropped during stall");
`endif

endmodule

>>> test/integer_matrix_multiply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_matrix_multiply_test: self-checking bench of the matrix multiplier
// Writes A and B element by element, issues multiply commands under many
// dimension settings and compares every result against a predicted product.
// ----------------------------------------------------------------------------

import imm_pkg::*;

localparam int MAT_DIM = MAX_DIM_DEF;

// one expected transaction on the result channel
typedef struct packed {
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [SUM_W-1:0] acc;
  logic                    dim_error;
  logic                    last;
} product_t;

// mirror of both stores and the dimension registers, plus pending products
class product_checker;
  localparam int MAX_REPORTS = 100;

  logic signed [VAL_W-1:0] a_mem [MAT_DIM*MAT_DIM];
  logic signed [VAL_W-1:0] b_mem [MAT_DIM*MAT_DIM];
  logic [CFG_W-1:0]        a_rows, a_cols, b_rows, b_cols;
  product_t                expected_products [$];
  int                      errors;

  function new();
    foreach (a_mem[i]) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
    end
    a_rows = DIM_RESET;
    a_cols = DIM_RESET;
    b_rows = DIM_RESET;
    b_cols = DIM_RESET;
    errors = 0;
  endfunction

  // length of the walk along one dimension: 0 acts as 1, large values saturate
  static function int walk_len(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAT_DIM) return MAT_DIM;
    return int'(v);
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      REG_A_ROWS: a_rows = data;
      REG_A_COLS: a_cols = data;
      REG_B_ROWS: b_rows = data;
      REG_B_COLS: b_cols = data;
      default: ;
    endcase
  endfunction

  // accepted command: update the stores or queue the whole product
  function void note_command(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] val);
    int       nr, nk, nc;
    longint   acc;
    product_t p;
    case (op)
      OP_WR_A: a_mem[int'(row) * MAT_DIM + int'(col)] = val;
      OP_WR_B: b_mem[int'(row) * MAT_DIM + int'(col)] = val;
      OP_MUL: begin
        if (a_cols != b_rows) begin
          // dimension mismatch: a single flagged result
          p = '0;
          p.dim_error = 1'b1;
          p.last = 1'b1;
          expected_products.push_back(p);
        end else begin
          nr = walk_len(a_rows);
          nk = walk_len(a_cols);
          nc = walk_len(b_cols);
          for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
              acc = 0;
              for (int k = 0; k < nk; k++) begin
                acc += longint'(a_mem[i * MAT_DIM + k]) * longint'(b_mem[k * MAT_DIM + j]);
              end
              p.row = IDX_W'(i);
              p.col = IDX_W'(j);
              p.acc = acc[SUM_W-1:0];
              p.dim_error = 1'b0;
              p.last = (i == nr - 1) && (j == nc - 1);
              expected_products.push_back(p);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  // accepted result: compare field by field with the oldest expectation
  task check_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                    logic signed [SUM_W-1:0] acc, logic dim_error, logic last);
    product_t want;
    if (expected_products.size() == 0) begin
      report($sformatf("unexpected result row %0d col %0d sum %0d", row, col, acc));
      return;
    end
    want = expected_products.pop_front();
    if (row !== want.row)
      report($sformatf("out_row %0d, expected %0d", row, want.row));
    if (col !== want.col)
      report($sformatf("out_col %0d, expected %0d", col, want.col));
    if (acc !== want.acc)
      report($sformatf("product_sum %0d at (%0d,%0d), expected %0d",
                       acc, want.row, want.col, want.acc));
    if (dim_error !== want.dim_error)
      report($sformatf("dim_error %b, expected %b", dim_error, want.dim_error));
    if (last !== want.last)
      report($sformatf("last %b at (%0d,%0d), expected %b",
                       last, want.row, want.col, want.last));
  endtask

  task check_drained();
    if (expected_products.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_products.size()));
  endtask
endclass

module integer_matrix_multiply_test;

  localparam int CLK_PERIOD     = 20;
  localparam int ITEM_TARGET    = 410;
  localparam int IDLE_PCT       = 25;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [OP_W-1:0]         OP_UNUSED = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN   = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MAX   = 16'sh7fff;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  imm_in_if  in_chan ();
  imm_out_if out_chan ();

  product_checker sb;

  bit steady;        // no idling on either side while set
  bit hold_req;      // asks the receiver for one long hold-off
  int quiet_cycles;
  int items_sent;
  bit a_known [MAT_DIM*MAT_DIM];
  bit b_known [MAT_DIM*MAT_DIM];

  integer_matrix_multiply uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // monitor: register writes, accepted commands and results, plus watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_register(cfg_index, cfg_data);
      if (in_chan.valid && in_chan.ready)
        sb.note_command(in_chan.operation, in_chan.elem_row, in_chan.elem_col,
                        in_chan.elem_value);
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.out_row, out_chan.out_col, out_chan.product_sum,
                        out_chan.dim_error, out_chan.last);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // offer one command, with random gaps, and wait for its transaction
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                          input logic [IDX_W-1:0] col,
                          input logic signed [VAL_W-1:0] val);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= op;
    in_chan.elem_row   <= row;
    in_chan.elem_col   <= col;
    in_chan.elem_value <= val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (op == OP_WR_A) a_known[int'(row) * MAT_DIM + int'(col)] = 1'b1;
    if (op == OP_WR_B) b_known[int'(row) * MAT_DIM + int'(col)] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
  endtask

  // stop offering, wait for every expected result, then let the block settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_products.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ca,
                           input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb);
    wait_idle();
    write_reg(REG_A_ROWS, ra);
    write_reg(REG_A_COLS, ca);
    write_reg(REG_B_ROWS, rb);
    write_reg(REG_B_COLS, cb);
    cfg_we <= 1'b0;
  endtask

  // write the operand regions a product reads: all of it, or only the gaps
  task automatic fill_operands(input int nr, input int nk, input int nc,
                               input bit only_missing, input bit extreme);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!only_missing || !a_known[i * MAT_DIM + k])
          send_cmd(OP_WR_A, IDX_W'(i), IDX_W'(k), extreme ? VAL_MIN : VAL_W'($urandom));
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!only_missing || !b_known[k * MAT_DIM + j])
          send_cmd(OP_WR_B, IDX_W'(k), IDX_W'(j), extreme ? VAL_MIN : VAL_W'($urandom));
  endtask

  // one dimension setting: bursts of element writes, each closed by a multiply
  task automatic run_phase(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ca,
                           input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb,
                           input int n_mul, input bit hold);
    int nr, nk, nc, pick;
    configure(ra, ca, rb, cb);
    nr = sb.walk_len(ra);
    nk = sb.walk_len(ca);
    nc = sb.walk_len(cb);
    repeat (n_mul) begin
      repeat ($urandom_range(2, 12)) begin
        pick = $urandom_range(99);
        if (pick < 8)
          send_cmd(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
        else if (pick < 16)
          send_cmd(pick[0] ? OP_WR_B : OP_WR_A, IDX_W'($urandom), IDX_W'($urandom),
                   VAL_W'($urandom));
        else if (pick < 58)
          send_cmd(OP_WR_A, IDX_W'($urandom_range(0, nr - 1)),
                   IDX_W'($urandom_range(0, nk - 1)), VAL_W'($urandom));
        else
          send_cmd(OP_WR_B, IDX_W'($urandom_range(0, nk - 1)),
                   IDX_W'($urandom_range(0, nc - 1)), VAL_W'($urandom));
      end
      if (ca == rb) fill_operands(nr, nk, nc, 1'b1, 1'b0);
      if (hold) begin
        hold_req = 1'b1;
        hold = 1'b0;
      end
      send_cmd(OP_MUL, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
    end
  endtask

  initial begin
    int               sel;
    logic [CFG_W-1:0] ra, ca, rb, cb;

    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_A_ROWS;
    cfg_data           <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.operation  <= OP_WR_A;
    in_chan.elem_row   <= '0;
    in_chan.elem_col   <= '0;
    in_chan.elem_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 1x1 products of extreme values
    configure(4'd1, 4'd1, 4'd1, 4'd1);
    send_cmd(OP_WR_A, 3'd0, 3'd0, VAL_MIN);
    send_cmd(OP_WR_B, 3'd0, 3'd0, VAL_MIN);
    send_cmd(OP_MUL, 3'd0, 3'd0, '0);
    send_cmd(OP_WR_A, 3'd0, 3'd0, VAL_MAX);
    // unused operation code is dropped without a result
    send_cmd(OP_UNUSED, 3'd7, 3'd7, 16'shffff);
    send_cmd(OP_MUL, 3'd7, 3'd7, VAL_MAX);
    // writes at the far corner lie outside the 1x1 walk
    send_cmd(OP_WR_A, 3'd7, 3'd7, 16'sh5555);
    send_cmd(OP_WR_B, 3'd7, 3'd7, 16'shaaaa);
    send_cmd(OP_WR_B, 3'd0, 3'd0, VAL_MAX);
    send_cmd(OP_MUL, '0, '0, '0);
    // zero dimensions walk as one
    configure(4'd0, 4'd0, 4'd0, 4'd0);
    send_cmd(OP_MUL, '0, '0, '0);
    // mismatched inner dimensions give a single error result
    configure(4'd1, 4'd2, 4'd3, 4'd1);
    send_cmd(OP_MUL, '0, '0, '0);
    configure(4'd15, 4'd0, 4'd15, 4'd0);
    send_cmd(OP_MUL, '0, '0, '0);

    // receiver holds off while commands keep coming
    run_phase(4'd4, 4'd4, 4'd4, 4'd4, 2, 1'b1);

    // no idling: full 8x8 operands at the most negative value, largest sum
    steady = 1'b1;
    configure(4'd8, 4'd8, 4'd8, 4'd8);
    fill_operands(MAT_DIM, MAT_DIM, MAT_DIM, 1'b0, 1'b1);
    send_cmd(OP_MUL, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
    run_phase(4'd15, 4'd15, 4'd15, 4'd15, 2, 1'b0);
    steady = 1'b0;

    // random settings: mostly small, some up to 8, some out of range, some mismatched
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(99);
      ra = CFG_W'($urandom_range(1, 4));
      ca = CFG_W'($urandom_range(1, 4));
      cb = CFG_W'($urandom_range(1, 4));
      if (sel >= 60 && sel < 78) begin
        ra = CFG_W'($urandom_range(1, 8));
        ca = CFG_W'($urandom_range(1, 8));
        cb = CFG_W'($urandom_range(1, 8));
      end else if (sel >= 78 && sel < 88) begin
        ra = CFG_W'($urandom_range(0, 15));
        ca = CFG_W'($urandom_range(0, 15));
        cb = CFG_W'($urandom_range(0, 15));
      end
      rb = ca;
      if (sel >= 88)
        while (rb == ca) rb = CFG_W'($urandom_range(0, 15));
      run_phase(ra, ca, rb, cb, $urandom_range(1, 3), 1'b0);
    end

    wait_idle();
    sb.check_drained();
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
rtl/imm_pkg.sv
rtl/imm_if.sv
rtl/imm_ram.sv
rtl/imm_mac.sv
rtl/imm_seq.sv
rtl/integer_matrix_multiply.sv
test/integer_matrix_multiply_test.sv
